// ===== rtl/core/tsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_pkg: shared definitions of the task slot pool
// command codes, field widths and the default pool size
// ----------------------------------------------------------------------------
package tsp_pkg;

  // field widths
  localparam int CMD_W   = 3;
  localparam int SLOT_W  = 4;
  localparam int SSIZE_W = 8;
  localparam int ROUT_W  = 32;
  localparam int CNT_W   = 5;
  localparam int DEPTH_W = 8;

  // default number of task slots
  localparam int unsigned NUM_SLOTS_DEF = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INIT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP   = 3'd4;

endpackage
`default_nettype wire

// ===== rtl/core/task_slot_pool_with_call_depth_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// task_slot_pool_with_call_depth_unit: task slot allocator with call depth
// free list of task slots in slot memory, live bits and per-slot call depth
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o) carries one command per transfer:
//   init, alloc, free, push or pop, with slot, stack_size, routine and count
//   output channel (out_valid_o / out_stall_i) returns one result per command:
//   ok, given_slot and the call depth of the reported slot
// timing
//   a command is taken in idle, the slot memories are read on that edge and
//   the command is then executed in S_EXEC, which loads the output register
//   a new command is taken only in idle, so commands never overlap
//   init with n slots (count saturated to the pool size) walks the free-list
//   memory one link per cycle
//   the single read/modify/write step on the slot memories serialises commands
// reset
//   pool empty, all slots not live; slot memories hold no reset value
// receiver stall
//   a waiting result stays in the output register; the next command is still
//   taken, but its execute step holds until the output register frees up
// ----------------------------------------------------------------------------
module task_slot_pool_with_call_depth_unit #(
  parameter int unsigned NUM_SLOTS = tsp_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // command channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [tsp_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic [tsp_pkg::SLOT_W-1:0]  slot_i,
  input  wire logic [tsp_pkg::SSIZE_W-1:0] stack_size_i,
  input  wire logic [tsp_pkg::ROUT_W-1:0]  routine_i,
  input  wire logic [tsp_pkg::CNT_W-1:0]   count_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             ok_o,
  output logic [tsp_pkg::SLOT_W-1:0]       given_slot_o,
  output logic [tsp_pkg::DEPTH_W-1:0]      depth_o
);

  // slot index width and pointer width (pointer also codes null)
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PW = $clog2(NUM_SLOTS + 1);
  localparam int SW = tsp_pkg::SLOT_W;
  localparam int DW = tsp_pkg::DEPTH_W;
  localparam logic [PW-1:0] NULL_PTR = PW'(NUM_SLOTS);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0] state_q, state_d;

  // command held for the execute step
  logic [tsp_pkg::CMD_W-1:0]   cmd_q;
  logic [SW-1:0]               slot_q;
  logic [tsp_pkg::SSIZE_W-1:0] ssize_q;
  logic                        rt_nz_q;
  logic [PW-1:0]               n_q;

  // pool state
  logic [PW-1:0]        free_head_q, free_head_d;
  logic [NUM_SLOTS-1:0] live_q, live_d;
  logic [AW-1:0]        walk_idx_q, walk_idx_d;

  // slot memories
  logic [PW-1:0] next_free_mem [NUM_SLOTS];
  logic [DW-1:0] call_depth_mem [NUM_SLOTS];
  logic [DW-1:0] depth_limit_mem [NUM_SLOTS];
  logic [PW-1:0] nf_rd_q;
  logic [DW-1:0] cd_rd_q;
  logic [DW-1:0] lim_rd_q;

  logic          nf_we;
  logic [AW-1:0] nf_waddr;
  logic [PW-1:0] nf_wdata;
  logic          cd_we;
  logic          lim_we;
  logic [AW-1:0] dl_waddr;
  logic [DW-1:0] cd_wdata;

  // output register
  logic          out_valid_q, out_valid_d;
  logic          ok_q, ok_d;
  logic [SW-1:0] given_q, given_d;
  logic [DW-1:0] depth_q, depth_d;

  logic          in_xfer;
  logic          out_free;
  logic          produce;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] sidx;
  logic [AW-1:0] hidx;
  logic          in_range;
  logic          live;
  logic          head_null;
  logic          walk_last;
  logic [PW-1:0] n_d;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // alloc reads the links of the head slot, every other command its own slot
  assign rd_addr = (cmd_i == tsp_pkg::CMD_ALLOC) ? AW'(free_head_q) : AW'(slot_i);

  // init count saturates to the pool size
  assign n_d = (32'(count_i) > 32'(NUM_SLOTS)) ? PW'(NUM_SLOTS) : PW'(count_i);

  assign sidx      = AW'(slot_q);
  assign hidx      = AW'(free_head_q);
  assign in_range  = (32'(slot_q) < 32'(NUM_SLOTS));
  assign live      = in_range && live_q[sidx];
  assign head_null = (free_head_q == NULL_PTR);
  assign walk_last = (PW'(walk_idx_q) == (n_q - PW'(1)));

  // sequencer and the shared compare/increment step
  always_comb begin
    state_d     = state_q;
    free_head_d = free_head_q;
    live_d      = live_q;
    walk_idx_d  = walk_idx_q;
    nf_we       = 1'b0;
    nf_waddr    = sidx;
    nf_wdata    = free_head_q;
    cd_we       = 1'b0;
    lim_we      = 1'b0;
    dl_waddr    = sidx;
    cd_wdata    = cd_rd_q;
    produce     = 1'b0;
    ok_d        = 1'b0;
    given_d     = slot_q;
    depth_d     = live ? cd_rd_q : '0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          produce = 1'b1;
          state_d = S_IDLE;
          case (cmd_q)
            tsp_pkg::CMD_INIT: begin
              if (n_q != '0) begin
                // rebuild the pool: result comes out at the end of the walk
                produce    = 1'b0;
                state_d    = S_WALK;
                live_d     = '0;
                walk_idx_d = '0;
              end
            end
            tsp_pkg::CMD_ALLOC: begin
              depth_d = '0;
              if (ssize_q != '0 && rt_nz_q && !head_null) begin
                ok_d         = 1'b1;
                given_d      = SW'(free_head_q);
                free_head_d  = nf_rd_q;
                live_d[hidx] = 1'b1;
                dl_waddr     = hidx;
                cd_we        = 1'b1;
                lim_we       = 1'b1;
                cd_wdata     = '0;
              end
            end
            tsp_pkg::CMD_FREE: begin
              if (live) begin
                ok_d         = 1'b1;
                depth_d      = '0;
                live_d[sidx] = 1'b0;
                nf_we        = 1'b1;
                free_head_d  = PW'(slot_q);
              end
            end
            tsp_pkg::CMD_PUSH: begin
              if (live && rt_nz_q && cd_rd_q < lim_rd_q) begin
                ok_d     = 1'b1;
                cd_we    = 1'b1;
                cd_wdata = cd_rd_q + DW'(1);
                depth_d  = cd_wdata;
              end
            end
            tsp_pkg::CMD_POP: begin
              if (live && cd_rd_q <= lim_rd_q && cd_rd_q != '0) begin
                ok_d     = 1'b1;
                cd_we    = 1'b1;
                cd_wdata = cd_rd_q - DW'(1);
                depth_d  = cd_wdata;
              end
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      S_WALK: begin
        // slot i links to slot i-1, slot 0 ends the list
        nf_we    = 1'b1;
        nf_waddr = walk_idx_q;
        nf_wdata = (walk_idx_q == '0) ? NULL_PTR : PW'(walk_idx_q - AW'(1));
        ok_d     = 1'b1;
        depth_d  = '0;
        if (walk_last) begin
          if (out_free) begin
            produce     = 1'b1;
            free_head_d = PW'(walk_idx_q);
            state_d     = S_IDLE;
          end
        end else begin
          walk_idx_d = walk_idx_q + AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (produce) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= NULL_PTR;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q   <= cmd_i;
      slot_q  <= slot_i;
      ssize_q <= stack_size_i;
      rt_nz_q <= (routine_i != '0);
      n_q     <= n_d;
    end
    walk_idx_q <= walk_idx_d;
    if (produce) begin
      ok_q    <= ok_d;
      given_q <= given_d;
      depth_q <= depth_d;
    end
  end

  // slot memories: one registered read at transfer, one write per cycle
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      nf_rd_q  <= next_free_mem[rd_addr];
      cd_rd_q  <= call_depth_mem[rd_addr];
      lim_rd_q <= depth_limit_mem[rd_addr];
    end
    if (nf_we) begin
      next_free_mem[nf_waddr] <= nf_wdata;
    end
    if (cd_we) begin
      call_depth_mem[dl_waddr] <= cd_wdata;
    end
    if (lim_we) begin
      depth_limit_mem[dl_waddr] <= ssize_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign given_slot_o = given_q;
  assign depth_o      = depth_q;

  // free list head is a slot or null
  a_head_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= NULL_PTR)
    else $error("free list head out of range");

  // an accepted command enters the execute state in the next cycle
  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_EXEC)
    else $error("accepted command not executed");

  // the init walk stays inside the saturated count
  a_walk_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> (PW'(walk_idx_q) < n_q))
    else $error("init walk beyond count");

endmodule
`default_nettype wire

// ===== sim/tsp_pool_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_pool_checker: result checker of the task slot pool
// follows every command transfer with its own copy of the free list, live
// bits and call depths, and compares each result transfer with its prediction
// ----------------------------------------------------------------------------
module tsp_pool_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [tsp_pkg::CMD_W-1:0]     cmd_i,
  input  logic [tsp_pkg::SLOT_W-1:0]    slot_i,
  input  logic [tsp_pkg::SSIZE_W-1:0]   stack_size_i,
  input  logic [tsp_pkg::ROUT_W-1:0]    routine_i,
  input  logic [tsp_pkg::CNT_W-1:0]     count_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          ok_i,
  input  logic [tsp_pkg::SLOT_W-1:0]    given_slot_i,
  input  logic [tsp_pkg::DEPTH_W-1:0]   depth_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   waiting_o
);

  localparam int unsigned       NSLOT   = tsp_pkg::NUM_SLOTS_DEF;
  localparam int                LINK_W  = $clog2(NSLOT + 1);
  localparam int                SW      = tsp_pkg::SLOT_W;
  localparam int                DW      = tsp_pkg::DEPTH_W;
  localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(NSLOT);

  typedef struct packed {
    logic          ok;
    logic [SW-1:0] slot;
    logic [DW-1:0] depth;
  } pool_result_t;

  logic [LINK_W-1:0] free_head;
  logic [LINK_W-1:0] next_link  [NSLOT];
  logic              slot_live  [NSLOT];
  logic [DW-1:0]     call_depth [NSLOT];
  logic [DW-1:0]     depth_cap  [NSLOT];
  pool_result_t      due_results[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns  mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  // applies one command to the pool copy and returns the result it causes
  function automatic pool_result_t pool_apply(
      input logic [tsp_pkg::CMD_W-1:0]   cmd,
      input logic [SW-1:0]               slot,
      input logic [tsp_pkg::SSIZE_W-1:0] stack_size,
      input logic [tsp_pkg::ROUT_W-1:0]  routine,
      input logic [tsp_pkg::CNT_W-1:0]   count);
    pool_result_t      res;
    int unsigned       fill;
    logic [LINK_W-1:0] head;
    res.ok    = 1'b0;
    res.slot  = slot;
    res.depth = '0;
    case (cmd)
      tsp_pkg::CMD_INIT: begin
        if (count != 0) begin
          fill = (count > NSLOT) ? NSLOT : count;
          for (int i = 0; i < NSLOT; i++) slot_live[i] = 1'b0;
          free_head = NO_SLOT;
          for (int i = 0; i < fill; i++) begin
            next_link[i] = free_head;
            free_head    = LINK_W'(i);
          end
          res.ok = 1'b1;
        end
      end
      tsp_pkg::CMD_ALLOC: begin
        if (stack_size != 0 && routine != 0 && free_head < NSLOT) begin
          head             = free_head;
          free_head        = next_link[head];
          slot_live[head]  = 1'b1;
          call_depth[head] = '0;
          depth_cap[head]  = stack_size;
          res.slot         = head[SW-1:0];
          res.ok           = 1'b1;
        end
      end
      tsp_pkg::CMD_FREE: begin
        if (slot_live[slot]) begin
          slot_live[slot] = 1'b0;
          next_link[slot] = free_head;
          free_head       = LINK_W'(slot);
          res.ok          = 1'b1;
        end
      end
      tsp_pkg::CMD_PUSH: begin
        if (slot_live[slot] && routine != 0 && call_depth[slot] < depth_cap[slot]) begin
          call_depth[slot]++;
          res.ok = 1'b1;
        end
      end
      tsp_pkg::CMD_POP: begin
        if (slot_live[slot] && call_depth[slot] <= depth_cap[slot] &&
            call_depth[slot] != 0) begin
          call_depth[slot]--;
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    // a refused alloc reports depth 0, otherwise the depth of a live slot
    if (!(cmd == tsp_pkg::CMD_ALLOC && !res.ok) && slot_live[res.slot])
      res.depth = call_depth[res.slot];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pool_result_t seen;
    pool_result_t want;
    if (!rst_ni) begin
      free_head = NO_SLOT;
      for (int i = 0; i < NSLOT; i++) begin
        next_link[i]  = NO_SLOT;
        slot_live[i]  = 1'b0;
        call_depth[i] = '0;
        depth_cap[i]  = '0;
      end
      due_results.delete();
      fail_count_o = 0;
      waiting_o    = 0;
    end else begin
      // a result at this edge always belongs to an earlier command
      if (out_valid_i && !out_stall_i) begin
        seen = '{ok: ok_i, slot: given_slot_i, depth: depth_i};
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing expected", 32'(seen), '0);
        end else begin
          want = due_results.pop_front();
          if (seen.ok !== want.ok) report_mismatch("ok", 32'(seen.ok), 32'(want.ok));
          if (seen.slot !== want.slot)
            report_mismatch("given_slot", 32'(seen.slot), 32'(want.slot));
          if (seen.depth !== want.depth)
            report_mismatch("depth", 32'(seen.depth), 32'(want.depth));
        end
      end
      if (in_valid_i && !in_stall_i)
        due_results.push_back(pool_apply(cmd_i, slot_i, stack_size_i, routine_i, count_i));
      waiting_o = due_results.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level of the task slot pool simulation
// drives directed and random pool commands with random gaps and result
// stalls, one long result hold-off, and gives the verdict of the checker
// ----------------------------------------------------------------------------
module testbench;

  typedef logic [tsp_pkg::CMD_W-1:0]   cmd_t;
  typedef logic [tsp_pkg::SLOT_W-1:0]  slot_t;
  typedef logic [tsp_pkg::SSIZE_W-1:0] ssize_t;
  typedef logic [tsp_pkg::ROUT_W-1:0]  routine_t;
  typedef logic [tsp_pkg::CNT_W-1:0]   count_t;

  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  // result side hold-off that backs the block up into its command side
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned HOLD_AFTER   = 300;

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        in_valid   = 1'b0;
  logic                        in_stall;
  cmd_t                        cmd        = tsp_pkg::CMD_INIT;
  slot_t                       slot       = '0;
  ssize_t                      stack_size = '0;
  routine_t                    routine    = '0;
  count_t                      count      = '0;
  logic                        out_valid;
  logic                        out_stall  = 1'b0;
  logic                        ok;
  logic [tsp_pkg::SLOT_W-1:0]  given_slot;
  logic [tsp_pkg::DEPTH_W-1:0] depth;

  int unsigned fail_count;
  int unsigned waiting;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  // remaining commands of a stretch sent back to back
  int unsigned burst_left  = 0;

  task_slot_pool_with_call_depth_unit #(
    .NUM_SLOTS (tsp_pkg::NUM_SLOTS_DEF)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .slot_i       (slot),
    .stack_size_i (stack_size),
    .routine_i    (routine),
    .count_i      (count),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .ok_o         (ok),
    .given_slot_o (given_slot),
    .depth_o      (depth)
  );

  tsp_pool_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .cmd_i        (cmd),
    .slot_i       (slot),
    .stack_size_i (stack_size),
    .routine_i    (routine),
    .count_i      (count),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .ok_i         (ok),
    .given_slot_i (given_slot),
    .depth_i      (depth),
    .fail_count_o (fail_count),
    .waiting_o    (waiting)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit, counted in clock cycles
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offers one command after a random gap and waits for its transfer;
  // valid stays high when the next command follows without a gap
  task automatic put_command(input cmd_t c, input slot_t s, input ssize_t ss,
                             input routine_t rt, input count_t n);
    int unsigned gap;
    if (burst_left != 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 39) == 0) burst_left = 30;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    slot       <= s;
    stack_size <= ss;
    routine    <= rt;
    count      <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // random command mix: mostly alloc, push and pop on small depth limits so
  // that limits and empty pools are hit often, rare inits and unknown codes
  task automatic random_command();
    cmd_t        c;
    slot_t       s;
    ssize_t      ss;
    routine_t    rt;
    count_t      n;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    s    = slot_t'($urandom);
    ss   = ssize_t'($urandom);
    rt   = routine_t'($urandom);
    n    = count_t'($urandom);
    if (roll < 3) begin
      c = tsp_pkg::CMD_INIT;
      // mostly a full or partial pool, sometimes zero or above the pool size
      if ($urandom_range(0, 7) != 0)
        n = $urandom_range(0, 1) ? count_t'(tsp_pkg::NUM_SLOTS_DEF)
                                 : count_t'($urandom_range(1, 16));
    end else if (roll < 30) begin
      c = tsp_pkg::CMD_ALLOC;
    end else if (roll < 46) begin
      c = tsp_pkg::CMD_FREE;
    end else if (roll < 74) begin
      c = tsp_pkg::CMD_PUSH;
    end else if (roll < 98) begin
      c = tsp_pkg::CMD_POP;
    end else begin
      c = tsp_pkg::CMD_POP + cmd_t'($urandom_range(1, 3));
    end
    case ($urandom_range(0, 9))
      0: begin
        ss = '0;
      end
      1, 2, 3, 4, 5, 6: begin
        ss = ssize_t'($urandom_range(1, 3));
      end
      default: ;
    endcase
    if ($urandom_range(0, 11) == 0) rt = '0;
    put_command(c, s, ss, rt, n);
  endtask

  // result side: random stalls with quiet stretches, and one long hold-off
  // once traffic is going so that the block fills up and stalls its input
  initial begin : result_stall
    int unsigned stall_len;
    int unsigned run_len;
    logic        held_long;
    held_long = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (!held_long && items_sent >= HOLD_AFTER) begin
        held_long = 1'b1;
        stall_len = LONG_HOLD;
      end else begin
        stall_len = pick_gap();
      end
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 4);
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (run_len) @(posedge clk);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    put_command(tsp_pkg::CMD_ALLOC, 4'd3, 8'd5, 32'h1, 5'd0);     // pool empty after reset
    put_command(tsp_pkg::CMD_POP, 4'd15, 8'd0, 32'h1, 5'd0);      // slot not live
    put_command(tsp_pkg::CMD_INIT, 4'd0, 8'd0, 32'h0, 5'd0);      // zero count refused
    put_command(tsp_pkg::CMD_INIT, 4'd9, 8'hff, 32'hffff_ffff, 5'd31);  // count saturates
    put_command(tsp_pkg::CMD_ALLOC, 4'd0, 8'd0, 32'h1234, 5'd0);  // zero stack size
    put_command(tsp_pkg::CMD_ALLOC, 4'd0, 8'd1, 32'h0, 5'd0);     // no routine
    put_command(tsp_pkg::CMD_ALLOC, 4'd0, 8'd1, 32'hffff_ffff, 5'd0);  // head 15, limit 1
    put_command(tsp_pkg::CMD_PUSH, 4'd15, 8'd0, 32'h0, 5'd0);     // push without routine
    put_command(tsp_pkg::CMD_PUSH, 4'd15, 8'd0, 32'h1, 5'd0);     // depth up to its limit
    put_command(tsp_pkg::CMD_PUSH, 4'd15, 8'd0, 32'h1, 5'd0);     // already at the limit
    put_command(tsp_pkg::CMD_POP, 4'd15, 8'd0, 32'h0, 5'd0);      // back to zero
    put_command(tsp_pkg::CMD_POP, 4'd15, 8'd0, 32'h0, 5'd0);      // depth already zero
    put_command(tsp_pkg::CMD_FREE, 4'd15, 8'd0, 32'h0, 5'd0);     // back to the head
    put_command(tsp_pkg::CMD_FREE, 4'd15, 8'd0, 32'h0, 5'd0);     // double free
    put_command(tsp_pkg::CMD_POP + 3'd3, 4'd15, 8'hff, 32'hffff_ffff, 5'd31);  // unknown code
    put_command(tsp_pkg::CMD_ALLOC, 4'd0, 8'hff, 32'h8000_0000, 5'd0);  // slot 15, widest
    put_command(tsp_pkg::CMD_ALLOC, 4'd7, 8'd2, 32'h1, 5'd0);     // slot 14
    put_command(tsp_pkg::CMD_INIT, 4'd0, 8'd0, 32'h0, 5'd2);      // rebuild with live slots
    put_command(tsp_pkg::CMD_PUSH, 4'd15, 8'd0, 32'h1, 5'd0);     // slot left out of the pool
    put_command(tsp_pkg::CMD_ALLOC, 4'd0, 8'd3, 32'h5, 5'd0);     // slot 1
    put_command(tsp_pkg::CMD_ALLOC, 4'd0, 8'd3, 32'h5, 5'd0);     // slot 0 ends the list
    put_command(tsp_pkg::CMD_ALLOC, 4'd6, 8'd3, 32'h5, 5'd0);     // pool used up
    put_command(tsp_pkg::CMD_FREE, 4'd1, 8'd0, 32'h0, 5'd0);
    put_command(tsp_pkg::CMD_INIT, 4'd0, 8'd0, 32'h0, 5'd16);     // full pool again

    // random part
    repeat (RANDOM_ITEMS) random_command();
    in_valid <= 1'b0;

    // drain the outstanding results, then watch for stray ones
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
